FILE: src/adc_readout_pixel_descrambler_assert.svh
// Assertion macros shared by the descrambler RTL.
`ifndef ADC_READOUT_PIXEL_DESCRAMBLER_ASSERT_SVH
`define ADC_READOUT_PIXEL_DESCRAMBLER_ASSERT_SVH

// checked only outside reset
`define ARDESC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ARDESC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/ardesc_pkg.sv
// Types and fixed constants of the ADC readout pixel descrambler.
package ardesc_pkg;

   localparam int ROW_W   = 8;
   localparam int WAY_W   = 6;
   localparam int CHAN_W  = 2;
   localparam int ADC_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 15;
   localparam int COL_W   = 10;

   localparam int ADC_CHANNELS = 3;
   localparam int MUX_WAYS     = 46;

   localparam logic [WAY_W-1:0]  WAY_LAST  = WAY_W'(MUX_WAYS - 1);
   localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(ADC_CHANNELS - 1);

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [WAY_W-1:0]  way;
      logic [CHAN_W-1:0] chan;
      logic [ADC_W-1:0]  adc;
   } pos_type;

   typedef struct packed {
      logic               kept;
      logic               image_select;
      logic [INDEX_W-1:0] pixel_index;
      logic               frame_last;
   } place_type;

endpackage

FILE: src/ardesc_place.sv
// Maps a readout position to its image, pixel index and end-of-frame flag.
module ardesc_place #(
   parameter int ROWS           = 160,
   parameter int ADCS           = 4,
   parameter int KEPT_COLS      = 184,
   parameter int FIRST_KEPT_COL = 138
) (
   input  ardesc_pkg::pos_type   pos,
   output ardesc_pkg::place_type place
);
   import ardesc_pkg::*;

   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [ADC_W-1:0]  ADC_LAST = ADC_W'(ADCS - 1);
   localparam logic [COL_W-1:0]  CH_SPAN  = COL_W'(ADC_CHANNELS * MUX_WAYS);
   localparam logic [COL_W-1:0]  WAY_SPAN = COL_W'(MUX_WAYS);
   localparam logic [COL_W-1:0]  FIRST    = COL_W'(FIRST_KEPT_COL);
   localparam logic [COL_W-1:0]  SPAN     = COL_W'(2 * KEPT_COLS);
   localparam logic [15:0]       KEPT_W16 = 16'(KEPT_COLS);

   logic [ROW_W-1:0] flip_row;
   logic [ADC_W-1:0] adc_rev;
   logic [COL_W-1:0] col;
   logic [COL_W-1:0] offset;
   logic [15:0]      row_base;
   logic [15:0]      index_sum;
   logic             in_window;

   // reversed, interleaved column reduces to (ADCS-1-adc)*138 + chan*46 + way
   always_comb begin
      flip_row  = ROW_LAST - pos.row;
      adc_rev   = ADC_LAST - pos.adc;
      col       = COL_W'(adc_rev) * CH_SPAN + COL_W'(pos.chan) * WAY_SPAN
                  + COL_W'(pos.way);
      offset    = col - FIRST;
      in_window = (col >= FIRST) && (offset < SPAN);
      row_base  = 16'(flip_row) * KEPT_W16;
      index_sum = row_base + 16'(offset[COL_W-1:1]);

      place.kept         = in_window;
      place.image_select = in_window & offset[0];
      place.pixel_index  = in_window ? index_sum[INDEX_W-1:0] : '0;
      place.frame_last   = (pos.row == ROW_LAST) && (pos.way == WAY_LAST)
                           && (pos.chan == CHAN_LAST) && (pos.adc == ADC_LAST);
   end

endmodule

FILE: src/adc_readout_pixel_descrambler.sv
// Top level of the ADC readout pixel descrambler.
//
// req channel: one readout byte per transfer in req_tdata[7:0]; req_tuser set
// marks the first byte of a frame and restarts the position counters there.
// rsp channel: one result per input byte, in order. rsp_tdata carries the
// pixel index (bits 14:0) and the byte itself (bits 22:15); rsp_tuser holds
// the kept flag (bit 0) and the image select (bit 1); rsp_tlast flags the
// byte at the last position of a frame.
// A taken byte passes through the input register, then the result register,
// from which its result is offered; one byte per cycle while rsp_tready stays high.
// Both stages advance whenever the stage ahead is empty or moving, so a
// stall on rsp_tready backs up into req_tready only once both stages are
// full; nothing is dropped or repeated.
// Reset clears both stage valids and all position counters to zero.
`include "adc_readout_pixel_descrambler_assert.svh"

module adc_readout_pixel_descrambler #(
   parameter int ROWS           = 160,
   parameter int ADCS           = 4,
   parameter int KEPT_COLS      = 184,
   parameter int FIRST_KEPT_COL = 138
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [14:0] pixel_index, [22:15] pixel_value, [23] zero
   output logic [1:0]  rsp_tuser,   // [0] kept, [1] image_select
   output logic        rsp_tlast    // frame_last
);
   import ardesc_pkg::*;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [ADC_W-1:0] ADC_LAST = ADC_W'(ADCS - 1);

   pos_type           count_ff, count_in;
   pos_type           cur_pos;
   logic              a_valid_ff, a_valid_in;
   pos_type           a_pos_ff, a_pos_in;
   logic [BYTE_W-1:0] a_byte_ff, a_byte_in;
   logic              b_valid_ff, b_valid_in;
   place_type         b_place_ff, b_place_in;
   logic [BYTE_W-1:0] b_byte_ff, b_byte_in;
   place_type         place;
   logic              in_xfer, a_ready, b_ready;

   assign b_ready    = !b_valid_ff || rsp_tready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;
   assign in_xfer    = req_tvalid && a_ready;

   always_comb begin
      cur_pos  = req_tuser ? '0 : count_ff;
      count_in = count_ff;
      if (in_xfer) begin
         count_in = cur_pos;
         if (cur_pos.adc != ADC_LAST) begin
            count_in.adc = cur_pos.adc + ADC_W'(1);
         end else begin
            count_in.adc = '0;
            if (cur_pos.chan != CHAN_LAST) begin
               count_in.chan = cur_pos.chan + CHAN_W'(1);
            end else begin
               count_in.chan = '0;
               if (cur_pos.way != WAY_LAST) begin
                  count_in.way = cur_pos.way + WAY_W'(1);
               end else begin
                  count_in.way = '0;
                  count_in.row = (cur_pos.row == ROW_LAST) ? '0 : cur_pos.row + ROW_W'(1);
               end
            end
         end
      end
   end

   ardesc_place #(
      .ROWS           (ROWS),
      .ADCS           (ADCS),
      .KEPT_COLS      (KEPT_COLS),
      .FIRST_KEPT_COL (FIRST_KEPT_COL)
   ) u_place (
      .pos   (a_pos_ff),
      .place (place)
   );

   always_comb begin
      a_valid_in = a_ready ? req_tvalid : a_valid_ff;
      a_pos_in   = in_xfer ? cur_pos : a_pos_ff;
      a_byte_in  = in_xfer ? req_tdata : a_byte_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_place_in = (b_ready && a_valid_ff) ? place : b_place_ff;
      b_byte_in  = (b_ready && a_valid_ff) ? a_byte_ff : b_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pos_ff   <= a_pos_in;
      a_byte_ff  <= a_byte_in;
      b_place_ff <= b_place_in;
      b_byte_ff  <= b_byte_in;
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {1'b0, b_byte_ff, b_place_ff.pixel_index};
   assign rsp_tuser  = {b_place_ff.image_select, b_place_ff.kept};
   assign rsp_tlast  = b_place_ff.frame_last;

   `ARDESC_ASSERT_ALWAYS(a_reset_empties, reset |=> !a_valid_ff && !b_valid_ff, "stages not empty after reset")
   `ARDESC_ASSERT(a_counts_in_range, count_ff.adc <= ADC_LAST && count_ff.chan <= CHAN_LAST && count_ff.way <= WAY_LAST && count_ff.row <= ROW_LAST, "position counter out of range")
   `ARDESC_ASSERT(a_start_restarts, in_xfer && req_tuser |=> count_ff.adc == ADC_W'(1) && count_ff.chan == '0 && count_ff.way == '0 && count_ff.row == '0, "frame start did not restart counters")
   `ARDESC_ASSERT(a_stage_held, a_valid_ff && !b_ready |=> a_valid_ff && $stable(a_byte_ff), "input stage lost a byte under stall")
   `ARDESC_ASSERT(a_dropped_zero, rsp_tvalid && !b_place_ff.kept |-> b_place_ff.pixel_index == '0 && !b_place_ff.image_select, "dropped pixel carries placement")

endmodule

FILE: tb/sv/tb_adc_readout_pixel_descrambler.sv
// Self-checking testbench for the ADC readout pixel descrambler stream block.
module tb_adc_readout_pixel_descrambler;
   import ardesc_pkg::*;

   localparam int ROWS           = 160;
   localparam int ADCS           = 4;
   localparam int KEPT_COLS      = 184;
   localparam int FIRST_KEPT_COL = 138;
   localparam int COLS           = ADCS * ADC_CHANNELS * MUX_WAYS;
   localparam int RANDOM_BYTES   = 680;
   localparam int CYCLE_LIMIT    = 100000;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PRINT_LIMIT    = 40;

   typedef struct {
      logic [BYTE_W-1:0] raw_byte;
      logic              frame_start;
   } readout_byte_type;

   typedef struct {
      logic               kept;
      logic               image_select;
      logic [INDEX_W-1:0] pixel_index;
      logic [BYTE_W-1:0]  pixel_value;
      logic               frame_last;
   } pixel_place_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   readout_byte_type pending_bytes[$];
   pixel_place_type  expected_places[$];
   pos_type          position = '0;

   int cycle_count      = 0;
   int error_count      = 0;
   int result_count     = 0;
   int kept_count       = 0;
   int second_count     = 0;
   int frame_end_count  = 0;
   int restart_count    = 0;
   int burst_left       = 1;
   int gap_left         = 0;
   int stall_left       = 0;
   int run_left         = 0;
   int hold_left        = 0;
   bit hold_done        = 1'b0;

   adc_readout_pixel_descrambler #(
      .ROWS           (ROWS),
      .ADCS           (ADCS),
      .KEPT_COLS      (KEPT_COLS),
      .FIRST_KEPT_COL (FIRST_KEPT_COL)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic void queue_byte(logic [BYTE_W-1:0] value, logic start);
      readout_byte_type b;
      b.raw_byte    = value;
      b.frame_start = start;
      pending_bytes = {pending_bytes, b};
   endfunction

   // destination of one byte; advances the position counters
   function automatic pixel_place_type place_byte(logic [BYTE_W-1:0] value, logic start);
      pixel_place_type p;
      int row, way, chan, adc, flip_row, col, offset;
      if (start) position = '0;
      row  = int'(position.row);
      way  = int'(position.way);
      chan = int'(position.chan);
      adc  = int'(position.adc);
      flip_row = ROWS - 1 - row;
      col = COLS - 1 - (adc * ADC_CHANNELS * MUX_WAYS
                        + (ADC_CHANNELS - 1 - chan) * MUX_WAYS + (MUX_WAYS - 1 - way));
      p.kept         = (col >= FIRST_KEPT_COL) && (col - FIRST_KEPT_COL < 2 * KEPT_COLS);
      p.image_select = 1'b0;
      p.pixel_index  = '0;
      if (p.kept) begin
         offset         = col - FIRST_KEPT_COL;
         p.image_select = offset[0];
         p.pixel_index  = INDEX_W'(flip_row * KEPT_COLS + offset / 2);
      end
      p.pixel_value = value;
      p.frame_last  = (row == ROWS - 1) && (way == MUX_WAYS - 1)
                      && (chan == ADC_CHANNELS - 1) && (adc == ADCS - 1);
      if (adc + 1 < ADCS) begin
         position.adc = ADC_W'(adc + 1);
      end else begin
         position.adc = '0;
         if (chan + 1 < ADC_CHANNELS) begin
            position.chan = CHAN_W'(chan + 1);
         end else begin
            position.chan = '0;
            if (way + 1 < MUX_WAYS) begin
               position.way = WAY_W'(way + 1);
            end else begin
               position.way = '0;
               position.row = (row + 1 < ROWS) ? ROW_W'(row + 1) : '0;
            end
         end
      end
      return p;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      if (error_count < PRINT_LIMIT)
         $display("tb: mismatch in %s at result %0d: got %0d, expected %0d",
                  field, result_count, got, want);
      error_count++;
   endtask

   // sender: bursts of random length, random gaps between them
   always @(posedge clock) begin
      readout_byte_type next_byte;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_byte = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_byte.raw_byte;
            req_tuser  <= next_byte.frame_start;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, once, so the pipe backs up into the input
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && result_count >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         ready_next = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            run_left   = $urandom_range(1, 24);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         rsp_tready <= ready_next && (hold_left == 0);
      end
   end

   // predict on each input transfer, then check each output transfer
   always @(posedge clock) begin
      pixel_place_type want;
      pixel_place_type predicted;
      if (reset) begin
         position = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser) restart_count++;
            predicted       = place_byte(req_tdata, req_tuser);
            expected_places = {expected_places, predicted};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_places.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata, 0);
            end else begin
               want = expected_places.pop_front();
               if (rsp_tuser[0] !== want.kept)
                  report_mismatch("kept", rsp_tuser[0], want.kept);
               if (rsp_tuser[1] !== want.image_select)
                  report_mismatch("image_select", rsp_tuser[1], want.image_select);
               if (rsp_tdata[14:0] !== want.pixel_index)
                  report_mismatch("pixel_index", rsp_tdata[14:0], want.pixel_index);
               if (rsp_tdata[22:15] !== want.pixel_value)
                  report_mismatch("pixel_value", rsp_tdata[22:15], want.pixel_value);
               if (rsp_tlast !== want.frame_last)
                  report_mismatch("frame_last", rsp_tlast, want.frame_last);
               if (want.kept) kept_count++;
               if (want.image_select) second_count++;
               if (want.frame_last) frame_end_count++;
            end
            result_count <= result_count + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // frame start, byte extremes, first mux way across all ADCs and channels
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b0);
      for (int i = 0; i < 12; i++)
         queue_byte(8'h01 << (i % 8), 1'b0);
      // restart in mid frame, also back to back
      queue_byte(8'h80, 1'b1);
      queue_byte(8'h7F, 1'b1);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hC3, 1'b0);
      for (int i = 0; i < RANDOM_BYTES; i++)
         queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_places.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d bytes checked, %0d kept (%0d to second image)",
               result_count, kept_count, second_count);
      $display("tb: %0d frame ends seen, %0d counter restarts", frame_end_count, restart_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
